// File: rtl/mwdm_pkg.sv
// mwdm_pkg: widths, register codes and transaction types of the mecanum duty mixer
// no dependencies
`timescale 1ns / 1ps

package mwdm_pkg;

  localparam int unsigned VEL_W      = 16;
  localparam int unsigned WBS_W      = 16;
  localparam int unsigned LIM_W      = 15;
  localparam int unsigned PMD_W      = 16;
  localparam int unsigned DUTY_W     = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned WHEELS     = 4;
  localparam int unsigned FRAC_SHIFT = 16;
  localparam int unsigned WK_W       = VEL_W + WBS_W + 1;
  localparam int unsigned RAW_W      = WK_W + 1;
  localparam int unsigned MAG_W      = RAW_W - 1;
  localparam int unsigned QUO_W      = PMD_W;
  localparam int unsigned NUM_W      = MAG_W + QUO_W;

  localparam int DUTY_BITS_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int WH_FL = 0;
  localparam int WH_FR = 1;
  localparam int WH_RL = 2;
  localparam int WH_RR = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VEL    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DUTY   = 2'd2;

  localparam logic [WBS_W-1:0] WHEEL_BASE_RST = 16'd16384;
  localparam logic [LIM_W-1:0] MAX_VEL_RST    = 15'd4096;
  localparam logic [PMD_W-1:0] MAX_DUTY_RST   = 16'd1023;

  typedef struct packed {
    logic                    command;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic signed [VEL_W-1:0] yaw_rate;
  } cmd_t;

  typedef struct packed {
    logic [DUTY_W-1:0] fl_fwd_duty;
    logic [DUTY_W-1:0] fl_rev_duty;
    logic [DUTY_W-1:0] fr_fwd_duty;
    logic [DUTY_W-1:0] fr_rev_duty;
    logic [DUTY_W-1:0] rl_fwd_duty;
    logic [DUTY_W-1:0] rl_rev_duty;
    logic [DUTY_W-1:0] rr_fwd_duty;
    logic [DUTY_W-1:0] rr_rev_duty;
    logic              is_stopped;
    logic              was_scaled;
  } duty_t;

  typedef struct packed {
    logic [WBS_W-1:0] wheel_base_sum;
    logic [LIM_W-1:0] vel_limit;
    logic [PMD_W-1:0] duty_full;
  } cfg_t;

  typedef struct packed {
    logic                         stop;
    logic                         scaled;
    logic [WHEELS-1:0]            neg;
    logic [MAG_W-1:0]             divisor;
    logic [WHEELS-1:0][NUM_W-1:0] num;
  } job_t;

endpackage

// File: rtl/mwdm_ifs.sv
// mwdm_ifs: valid/ready channels for commands, queued jobs and duty results
// depends on mwdm_pkg
`timescale 1ns / 1ps

interface mwdm_cmd_if;
  logic           valid;
  logic           ready;
  mwdm_pkg::cmd_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface mwdm_job_if;
  logic           valid;
  logic           ready;
  mwdm_pkg::job_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface mwdm_duty_if;
  logic            valid;
  logic            ready;
  mwdm_pkg::duty_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/mwdm_front.sv
// mwdm_front: accepts commands, forms the four wheel values, divisor and numerators
// depends on mwdm_pkg and mwdm_ifs
`timescale 1ns / 1ps

module mwdm_front (
  input  logic                 clk,
  input  logic                 rst,
  input  mwdm_pkg::cfg_t       cfg,
  mwdm_cmd_if.sink             cmd,
  mwdm_job_if.source           job
);

  localparam int unsigned RAW_W = mwdm_pkg::RAW_W;
  localparam int unsigned MAG_W = mwdm_pkg::MAG_W;
  localparam int unsigned WK_W  = mwdm_pkg::WK_W;
  localparam int unsigned VEL_W = mwdm_pkg::VEL_W;
  localparam int unsigned NUM_W = mwdm_pkg::NUM_W;
  localparam int unsigned WHEELS = mwdm_pkg::WHEELS;
  localparam int unsigned FRAC_SHIFT = mwdm_pkg::FRAC_SHIFT;

  logic                    a_valid;
  logic                    a_ready;
  logic                    a_cmd;
  logic signed [VEL_W-1:0] a_vx;
  logic signed [VEL_W-1:0] a_vy;
  logic signed [WK_W-1:0]  a_wk;
  logic signed [WK_W-1:0]  wk_prod;

  logic                    b_valid;
  logic                    b_ready;
  logic                    b_cmd;
  logic [MAG_W-1:0]        b_mag [WHEELS];
  logic [WHEELS-1:0]       b_neg;

  logic signed [RAW_W-1:0] vx_s;
  logic signed [RAW_W-1:0] vy_s;
  logic signed [RAW_W-1:0] wk_s;
  logic signed [RAW_W-1:0] raw [WHEELS];

  logic [MAG_W-1:0]        m01;
  logic [MAG_W-1:0]        m23;
  logic [MAG_W-1:0]        m_max;
  logic [MAG_W-1:0]        lim;
  logic                    scaled;

  // stage a: capture and form yaw term
  assign wk_prod   = $signed(cmd.payload.yaw_rate) * $signed({1'b0, cfg.wheel_base_sum});
  assign a_ready   = !a_valid || b_ready;
  assign cmd.ready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && a_ready) begin
      a_cmd <= cmd.payload.command;
      a_vx  <= cmd.payload.vel_x;
      a_vy  <= cmd.payload.vel_y;
      a_wk  <= wk_prod;
    end
  end

  // stage b: wheel values and magnitudes
  always_comb begin
    vx_s = RAW_W'($signed({a_vx, {FRAC_SHIFT{1'b0}}}));
    vy_s = RAW_W'($signed({a_vy, {FRAC_SHIFT{1'b0}}}));
    wk_s = RAW_W'(a_wk);
    raw[mwdm_pkg::WH_FL] = vx_s - vy_s - wk_s;
    raw[mwdm_pkg::WH_FR] = vx_s + vy_s + wk_s;
    raw[mwdm_pkg::WH_RL] = vx_s + vy_s - wk_s;
    raw[mwdm_pkg::WH_RR] = vx_s - vy_s + wk_s;
  end

  assign b_ready = !b_valid || job.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && b_ready) begin
      b_cmd <= a_cmd;
      for (int i = 0; i < WHEELS; i++) begin
        b_neg[i] <= raw[i][RAW_W-1];
        b_mag[i] <= raw[i][RAW_W-1] ? MAG_W'(-raw[i]) : MAG_W'(raw[i]);
      end
    end
  end

  // stage c: peak magnitude, divisor, numerators, into the queue
  always_comb begin
    m01    = (b_mag[0] > b_mag[1]) ? b_mag[0] : b_mag[1];
    m23    = (b_mag[2] > b_mag[3]) ? b_mag[2] : b_mag[3];
    m_max  = (m01 > m23) ? m01 : m23;
    lim    = MAG_W'({cfg.vel_limit, {FRAC_SHIFT{1'b0}}});
    scaled = m_max > lim;
  end

  assign job.valid = b_valid;

  always_comb begin
    job.payload.stop    = b_cmd;
    job.payload.scaled  = scaled;
    job.payload.neg     = b_neg;
    job.payload.divisor = scaled ? m_max : lim;
    for (int i = 0; i < WHEELS; i++) begin
      job.payload.num[i] = NUM_W'(b_mag[i]) * NUM_W'(cfg.duty_full);
    end
  end

endmodule

// File: rtl/mwdm_queue.sv
// mwdm_queue: short job queue between the front and the divider back end
// depends on mwdm_pkg and mwdm_ifs
`timescale 1ns / 1ps

module mwdm_queue #(
  parameter int DEPTH = mwdm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  mwdm_job_if.sink   wr,
  mwdm_job_if.source rd
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  mwdm_pkg::job_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign wr.ready   = count != CNT_W'(DEPTH);
  assign rd.valid   = count != '0;
  assign rd.payload = mem[rd_ptr];
  assign push       = wr.valid && wr.ready;
  assign pop        = rd.valid && rd.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr.payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/mwdm_back.sv
// mwdm_back: four-lane radix-2 divider and duty result register
// depends on mwdm_pkg and mwdm_ifs
`timescale 1ns / 1ps

module mwdm_back #(
  parameter int DUTY_BITS = mwdm_pkg::DUTY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  mwdm_job_if.sink    job,
  mwdm_duty_if.source duty
);

  localparam int unsigned MAG_W  = mwdm_pkg::MAG_W;
  localparam int unsigned QUO_W  = mwdm_pkg::QUO_W;
  localparam int unsigned NUM_W  = mwdm_pkg::NUM_W;
  localparam int unsigned DUTY_W = mwdm_pkg::DUTY_W;
  localparam int unsigned WHEELS = mwdm_pkg::WHEELS;
  localparam int unsigned CNT_W  = $clog2(QUO_W);
  localparam logic [DUTY_W-1:0] DUTY_CLAMP = (DUTY_BITS >= DUTY_W) ? {DUTY_W{1'b1}} :
                                             DUTY_W'((64'd1 << DUTY_BITS) - 64'd1);

  typedef struct packed {
    logic [MAG_W-1:0] rem;
    logic             q;
  } div_step_t;

  function automatic div_step_t div_step(input logic [MAG_W-1:0] rem,
                                         input logic             nbit,
                                         input logic [MAG_W-1:0] d);
    logic [MAG_W:0] t;
    div_step_t      r;
    t = {rem, nbit};
    if (t >= {1'b0, d}) begin
      r.rem = MAG_W'(t - {1'b0, d});
      r.q   = 1'b1;
    end else begin
      r.rem = t[MAG_W-1:0];
      r.q   = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [DUTY_W-1:0] to_duty(input logic [QUO_W-1:0] q,
                                                input logic             dzero);
    logic [DUTY_W-1:0] v;
    v = DUTY_W'(q);
    if (dzero) begin
      v = '0;
    end else if (v > DUTY_CLAMP) begin
      v = DUTY_CLAMP;
    end
    return v;
  endfunction

  logic                    busy;
  logic [CNT_W-1:0]        cnt;
  logic                    stop_r;
  logic                    scaled_r;
  logic [WHEELS-1:0]       neg_r;
  logic [MAG_W-1:0]        div_r;
  logic [MAG_W-1:0]        rem_r  [WHEELS];
  logic [QUO_W-2:0]        low_r  [WHEELS];
  logic [QUO_W-1:0]        quo_r  [WHEELS];
  div_step_t               first_s [WHEELS];
  div_step_t               next_s  [WHEELS];

  logic                    done;
  logic                    out_free;
  logic                    finish;
  logic                    load;
  logic                    out_valid;
  mwdm_pkg::duty_t         out_data;
  logic [DUTY_W-1:0]       lane_duty [WHEELS];
  logic [DUTY_W-1:0]       lane_fwd  [WHEELS];
  logic [DUTY_W-1:0]       lane_rev  [WHEELS];

  assign done     = busy && (cnt == '0);
  assign out_free = !out_valid || duty.ready;
  assign finish   = done && out_free;
  assign job.ready = !busy || finish;
  assign load     = job.valid && job.ready;

  always_comb begin
    for (int i = 0; i < WHEELS; i++) begin
      first_s[i] = div_step(job.payload.num[i][NUM_W-1:QUO_W], job.payload.num[i][QUO_W-1],
                            job.payload.divisor);
      next_s[i]  = div_step(rem_r[i], low_r[i][QUO_W-2], div_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(QUO_W - 1);
    end else begin
      if (finish) begin
        busy <= 1'b0;
      end
      if (busy && cnt != '0) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stop_r   <= job.payload.stop;
      scaled_r <= job.payload.scaled;
      neg_r    <= job.payload.neg;
      div_r    <= job.payload.divisor;
      for (int i = 0; i < WHEELS; i++) begin
        rem_r[i] <= first_s[i].rem;
        quo_r[i] <= QUO_W'(first_s[i].q);
        low_r[i] <= job.payload.num[i][QUO_W-2:0];
      end
    end else if (busy && cnt != '0) begin
      for (int i = 0; i < WHEELS; i++) begin
        rem_r[i] <= next_s[i].rem;
        quo_r[i] <= {quo_r[i][QUO_W-2:0], next_s[i].q};
        low_r[i] <= {low_r[i][QUO_W-3:0], 1'b0};
      end
    end
  end

  // steer each duty to the forward or reverse bridge input
  always_comb begin
    for (int i = 0; i < WHEELS; i++) begin
      lane_duty[i] = stop_r ? '0 : to_duty(quo_r[i], div_r == '0);
      lane_fwd[i]  = neg_r[i] ? '0 : lane_duty[i];
      lane_rev[i]  = neg_r[i] ? lane_duty[i] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (duty.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_data.fl_fwd_duty <= lane_fwd[mwdm_pkg::WH_FL];
      out_data.fl_rev_duty <= lane_rev[mwdm_pkg::WH_FL];
      out_data.fr_fwd_duty <= lane_fwd[mwdm_pkg::WH_FR];
      out_data.fr_rev_duty <= lane_rev[mwdm_pkg::WH_FR];
      out_data.rl_fwd_duty <= lane_fwd[mwdm_pkg::WH_RL];
      out_data.rl_rev_duty <= lane_rev[mwdm_pkg::WH_RL];
      out_data.rr_fwd_duty <= lane_fwd[mwdm_pkg::WH_RR];
      out_data.rr_rev_duty <= lane_rev[mwdm_pkg::WH_RR];
      out_data.is_stopped  <= stop_r;
      out_data.was_scaled  <= !stop_r && scaled_r;
    end
  end

  assign duty.valid   = out_valid;
  assign duty.payload = out_data;

endmodule

// File: rtl/mecanum_wheel_duty_mixer_core.sv
// mecanum_wheel_duty_mixer_core: top level, configuration registers and block wiring
// depends on mwdm_pkg, mwdm_ifs, mwdm_front, mwdm_queue and mwdm_back
`timescale 1ns / 1ps

// usage
//   cmd carries one velocity or stop command per transaction (valid/ready)
//   duty returns one transaction of eight bridge duties plus status per command,
//   in command order
//   cfg_we/cfg_index/cfg_data write wheel_base_sum (0), vel_limit (1) and
//   duty_full (2); write only while no command is in flight
// the divider takes a new job only as it finishes the last; its four radix-2 lanes
//   produce one quotient bit per cycle for a 16-bit duty
// the front pipeline and the job queue keep taking commands while the divider runs,
//   and the result register lets the next division start while a result waits
// reset: synchronous, clears all handshake state and loads the register defaults
//   (wheel_base_sum 16384, vel_limit 4096, duty_full 1023)
// receiver stall: the result holds on duty until taken; the divider then stops,
//   the queue fills and cmd.ready drops

module mecanum_wheel_duty_mixer_core #(
  parameter int DUTY_BITS   = mwdm_pkg::DUTY_BITS_DEF,
  parameter int QUEUE_DEPTH = mwdm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [mwdm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mwdm_pkg::CFG_DATA_W-1:0]   cfg_data,
  mwdm_cmd_if.sink                          cmd,
  mwdm_duty_if.source                       duty
);

  mwdm_pkg::cfg_t cfg;

  mwdm_job_if q_in ();
  mwdm_job_if q_out ();

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wheel_base_sum <= mwdm_pkg::WHEEL_BASE_RST;
      cfg.vel_limit      <= mwdm_pkg::MAX_VEL_RST;
      cfg.duty_full      <= mwdm_pkg::MAX_DUTY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mwdm_pkg::CFG_WHEEL_BASE: cfg.wheel_base_sum <= cfg_data[mwdm_pkg::WBS_W-1:0];
        mwdm_pkg::CFG_MAX_VEL:    cfg.vel_limit      <= cfg_data[mwdm_pkg::LIM_W-1:0];
        mwdm_pkg::CFG_MAX_DUTY:   cfg.duty_full      <= cfg_data[mwdm_pkg::PMD_W-1:0];
        default: ;
      endcase
    end
  end

  mwdm_front u_front (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .cmd (cmd),
    .job (q_in)
  );

  mwdm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk (clk),
    .rst (rst),
    .wr  (q_in),
    .rd  (q_out)
  );

  mwdm_back #(
    .DUTY_BITS (DUTY_BITS)
  ) u_back (
    .clk  (clk),
    .rst  (rst),
    .job  (q_out),
    .duty (duty)
  );

endmodule

// File: rtl/mwdm_checker.sv
// mwdm_checker: port-level checks on the duty result channel, bound to the top level
// depends on mwdm_pkg and mecanum_wheel_duty_mixer_core
`timescale 1ns / 1ps

module mwdm_checker (
  input logic            clk,
  input logic            rst,
  input logic            duty_valid,
  input logic            duty_ready,
  input mwdm_pkg::duty_t duty_payload
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !duty_valid)
    else $error("result valid right after reset");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    duty_valid && !duty_ready |=> duty_valid && $stable(duty_payload))
    else $error("stalled result changed or dropped");

  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    duty_valid && duty_payload.is_stopped |->
      duty_payload.fl_fwd_duty == '0 && duty_payload.fl_rev_duty == '0 &&
      duty_payload.fr_fwd_duty == '0 && duty_payload.fr_rev_duty == '0 &&
      duty_payload.rl_fwd_duty == '0 && duty_payload.rl_rev_duty == '0 &&
      duty_payload.rr_fwd_duty == '0 && duty_payload.rr_rev_duty == '0 &&
      !duty_payload.was_scaled)
    else $error("stop transaction with nonzero duty or scaled flag");

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    duty_valid |->
      (duty_payload.fl_fwd_duty == '0 || duty_payload.fl_rev_duty == '0) &&
      (duty_payload.fr_fwd_duty == '0 || duty_payload.fr_rev_duty == '0) &&
      (duty_payload.rl_fwd_duty == '0 || duty_payload.rl_rev_duty == '0) &&
      (duty_payload.rr_fwd_duty == '0 || duty_payload.rr_rev_duty == '0))
    else $error("both bridge inputs of a wheel driven");

endmodule

bind mecanum_wheel_duty_mixer_core mwdm_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .duty_valid   (duty.valid),
  .duty_ready   (duty.ready),
  .duty_payload (duty.payload)
);

// File: sim/tb_top.sv
// tb_top: self-checking bench for mecanum_wheel_duty_mixer_core; directed rows, then random
// commands over several register settings, results compared with rows or a local mixer model
// depends on mwdm_pkg, mwdm_ifs and the core RTL
`timescale 1ns / 1ps

module tb_top;

  localparam int DUTY_BITS      = mwdm_pkg::DUTY_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int PHASES         = 9;
  localparam int PHASE_ITEMS    = 160;

  localparam int unsigned CFG_IDX_W  = mwdm_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W = mwdm_pkg::CFG_DATA_W;
  localparam int unsigned WHEELS     = mwdm_pkg::WHEELS;
  localparam int unsigned DUTY_W     = mwdm_pkg::DUTY_W;
  localparam int unsigned VEL_W      = mwdm_pkg::VEL_W;
  localparam int unsigned WBS_W      = mwdm_pkg::WBS_W;
  localparam int unsigned LIM_W      = mwdm_pkg::LIM_W;
  localparam int unsigned PMD_W      = mwdm_pkg::PMD_W;

  localparam logic CMD_DRIVE = 1'b0;
  localparam logic CMD_STOP  = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    mwdm_pkg::cmd_t    c;
    bit                typed;
    logic [WHEELS-1:0] neg;
    logic [DUTY_W-1:0] mag;
    bit                scaled;
  } dir_row_t;

  typedef struct packed {
    bit                    rnd;
    logic [CFG_DATA_W-1:0] wheel_base;
    logic [CFG_DATA_W-1:0] max_vel;
    logic [CFG_DATA_W-1:0] max_duty;
    bit                    poke_unused;
  } cfg_row_t;

  // neg bits: FL, FR, RL, RR from bit 0 up
  dir_row_t directed_rows [16] = '{
    '{'{CMD_STOP,  16'h0000, 16'h0000, 16'h0000}, 1'b1, 4'b0000, 16'd0,    1'b0},
    '{'{CMD_STOP,  16'h8000, 16'h7FFF, 16'hFFFF}, 1'b1, 4'b0000, 16'd0,    1'b0},
    '{'{CMD_DRIVE, 16'h0000, 16'h0000, 16'h0000}, 1'b1, 4'b0000, 16'd0,    1'b0},
    '{'{CMD_DRIVE, 16'h1000, 16'h0000, 16'h0000}, 1'b1, 4'b0000, 16'd1023, 1'b0},
    '{'{CMD_DRIVE, 16'hF000, 16'h0000, 16'h0000}, 1'b1, 4'b1111, 16'd1023, 1'b0},
    '{'{CMD_DRIVE, 16'h0000, 16'h1000, 16'h0000}, 1'b1, 4'b1001, 16'd1023, 1'b0},
    '{'{CMD_DRIVE, 16'h2000, 16'h0000, 16'h0000}, 1'b1, 4'b0000, 16'd1023, 1'b1},
    '{'{CMD_DRIVE, 16'h0001, 16'h0000, 16'h0000}, 1'b1, 4'b0000, 16'd0,    1'b0},
    '{'{CMD_DRIVE, 16'hFFFF, 16'h0000, 16'h0000}, 1'b1, 4'b1111, 16'd0,    1'b0},
    '{'{CMD_DRIVE, 16'h0000, 16'h0000, 16'h4000}, 1'b1, 4'b0101, 16'd1023, 1'b0},
    '{'{CMD_DRIVE, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 1'b0, 4'b0000, 16'd0,    1'b0},
    '{'{CMD_DRIVE, 16'h8000, 16'h8000, 16'h8000}, 1'b0, 4'b0000, 16'd0,    1'b0},
    '{'{CMD_DRIVE, 16'h7FFF, 16'h8000, 16'h0000}, 1'b0, 4'b0000, 16'd0,    1'b0},
    '{'{CMD_DRIVE, 16'h0000, 16'h0000, 16'h8000}, 1'b0, 4'b0000, 16'd0,    1'b0},
    '{'{CMD_DRIVE, 16'h5555, 16'hAAAA, 16'h00FF}, 1'b0, 4'b0000, 16'd0,    1'b0},
    '{'{CMD_DRIVE, 16'h8000, 16'h7FFF, 16'h7FFF}, 1'b0, 4'b0000, 16'd0,    1'b0}
  };

  cfg_row_t cfg_rows [PHASES] = '{
    '{1'b0, 16'd0,     16'd1,     16'd1,     1'b0},
    '{1'b0, 16'hFFFF,  16'h7FFF,  16'hFFFF,  1'b0},
    '{1'b0, 16'd40000, 16'd0,     16'd500,   1'b0},
    '{1'b0, 16'd12345, 16'd8000,  16'd0,     1'b0},
    '{1'b1, 16'd0,     16'd0,     16'd0,     1'b0},
    '{1'b0, 16'hFFFF,  16'd1,     16'hFFFF,  1'b0},
    '{1'b0, 16'd1,     16'h7FFF,  16'd1,     1'b0},
    '{1'b1, 16'd0,     16'd0,     16'd0,     1'b0},
    '{1'b0, 16'd16384, 16'hFFFF,  16'd1023,  1'b1}
  };

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mwdm_cmd_if  cmd_ch ();
  mwdm_duty_if duty_ch ();

  mecanum_wheel_duty_mixer_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd_ch),
    .duty      (duty_ch)
  );

  logic [WBS_W-1:0] wheel_base_q;
  logic [LIM_W-1:0] max_vel_q;
  logic [PMD_W-1:0] max_duty_q;

  mwdm_pkg::duty_t expected_duties [$];
  int    mismatch_count = 0;
  int    idle_cycles;
  int    send_idle;
  int    recv_idle;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic mwdm_pkg::duty_t mix_duties(input mwdm_pkg::cmd_t c);
    longint            raw [WHEELS];
    longint unsigned   mag [WHEELS];
    longint unsigned   peak, floor_vel, divisor, q, duty_cap, full_duty;
    longint            base, vx, vy, wk;
    logic [DUTY_W-1:0] fwd [WHEELS];
    logic [DUTY_W-1:0] rev [WHEELS];
    mwdm_pkg::duty_t   r;
    int                i;
    r = '0;
    if (c.command == CMD_STOP) begin
      r.is_stopped = 1'b1;
      return r;
    end
    base      = wheel_base_q;
    full_duty = max_duty_q;
    vx = $signed(c.vel_x);
    vx = vx * 65536;
    vy = $signed(c.vel_y);
    vy = vy * 65536;
    wk = $signed(c.yaw_rate);
    wk = wk * base;
    raw[mwdm_pkg::WH_FL] = vx - vy - wk;
    raw[mwdm_pkg::WH_FR] = vx + vy + wk;
    raw[mwdm_pkg::WH_RL] = vx + vy - wk;
    raw[mwdm_pkg::WH_RR] = vx - vy + wk;
    peak = 0;
    for (i = 0; i < WHEELS; i++) begin
      mag[i] = (raw[i] < 0) ? -raw[i] : raw[i];
      if (mag[i] > peak) peak = mag[i];
    end
    floor_vel = max_vel_q;
    floor_vel = floor_vel << 16;
    divisor   = (peak > floor_vel) ? peak : floor_vel;
    duty_cap  = (64'd1 << DUTY_BITS) - 1;
    for (i = 0; i < WHEELS; i++) begin
      q = (divisor != 0) ? (mag[i] * full_duty) / divisor : 0;
      if (q > duty_cap) q = duty_cap;
      fwd[i] = (raw[i] >= 0) ? q[DUTY_W-1:0] : '0;
      rev[i] = (raw[i] >= 0) ? '0 : q[DUTY_W-1:0];
    end
    r.fl_fwd_duty = fwd[mwdm_pkg::WH_FL];
    r.fl_rev_duty = rev[mwdm_pkg::WH_FL];
    r.fr_fwd_duty = fwd[mwdm_pkg::WH_FR];
    r.fr_rev_duty = rev[mwdm_pkg::WH_FR];
    r.rl_fwd_duty = fwd[mwdm_pkg::WH_RL];
    r.rl_rev_duty = rev[mwdm_pkg::WH_RL];
    r.rr_fwd_duty = fwd[mwdm_pkg::WH_RR];
    r.rr_rev_duty = rev[mwdm_pkg::WH_RR];
    r.was_scaled  = peak > floor_vel;
    return r;
  endfunction

  function automatic logic [VEL_W-1:0] random_vel();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      4:       return VEL_W'($urandom_range(8191)) - 16'd4096;
      default: return VEL_W'($urandom);
    endcase
  endfunction

  function automatic mwdm_pkg::cmd_t random_cmd();
    mwdm_pkg::cmd_t c;
    int unsigned    pick;
    pick       = $urandom_range(99);
    c.command  = (pick < 8) ? CMD_STOP : CMD_DRIVE;
    c.vel_x    = random_vel();
    c.vel_y    = random_vel();
    c.yaw_rate = random_vel();
    if (pick >= 8 && pick < 13) begin
      c.vel_x    = '0;
      c.vel_y    = '0;
      c.yaw_rate = '0;
    end
    return c;
  endfunction

  function automatic void check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      mwdm_pkg::CFG_WHEEL_BASE: wheel_base_q = data;
      mwdm_pkg::CFG_MAX_VEL:    max_vel_q = data[LIM_W-1:0];
      mwdm_pkg::CFG_MAX_DUTY:   max_duty_q = data;
      default: ;
    endcase
  endtask

  task automatic send_cmd(input mwdm_pkg::cmd_t c, input bit typed,
                          input mwdm_pkg::duty_t typed_duty);
    while ($urandom_range(99) < send_idle) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid   <= 1'b1;
    cmd_ch.payload <= c;
    do @(posedge clk); while (!cmd_ch.ready);
    expected_duties.push_back(typed ? typed_duty : mix_duties(c));
  endtask

  task automatic wait_drained();
    while (expected_duties.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    mwdm_pkg::duty_t want;
    if (rst) begin
      duty_ch.ready <= 1'b0;
    end else begin
      if (duty_ch.valid && duty_ch.ready) begin
        if (expected_duties.size() == 0) begin
          $error("duty transaction with no command outstanding");
          mismatch_count++;
        end else begin
          want = expected_duties.pop_front();
          check_field("fl_fwd_duty", want.fl_fwd_duty, duty_ch.payload.fl_fwd_duty);
          check_field("fl_rev_duty", want.fl_rev_duty, duty_ch.payload.fl_rev_duty);
          check_field("fr_fwd_duty", want.fr_fwd_duty, duty_ch.payload.fr_fwd_duty);
          check_field("fr_rev_duty", want.fr_rev_duty, duty_ch.payload.fr_rev_duty);
          check_field("rl_fwd_duty", want.rl_fwd_duty, duty_ch.payload.rl_fwd_duty);
          check_field("rl_rev_duty", want.rl_rev_duty, duty_ch.payload.rl_rev_duty);
          check_field("rr_fwd_duty", want.rr_fwd_duty, duty_ch.payload.rr_fwd_duty);
          check_field("rr_rev_duty", want.rr_rev_duty, duty_ch.payload.rr_rev_duty);
          check_field("is_stopped", want.is_stopped, duty_ch.payload.is_stopped);
          check_field("was_scaled", want.was_scaled, duty_ch.payload.was_scaled);
        end
      end
      duty_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (duty_ch.valid && duty_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    dir_row_t        row;
    cfg_row_t        setting;
    mwdm_pkg::duty_t want;
    int              p;
    int              n;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    cmd_ch.valid   = 1'b0;
    cmd_ch.payload = '0;
    send_idle      = 19;
    recv_idle      = 49;
    wheel_base_q   = mwdm_pkg::WHEEL_BASE_RST;
    max_vel_q      = mwdm_pkg::MAX_VEL_RST;
    max_duty_q     = mwdm_pkg::MAX_DUTY_RST;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row  = directed_rows[i];
      want = '0;
      want.is_stopped  = row.c.command == CMD_STOP;
      want.was_scaled  = row.scaled;
      want.fl_fwd_duty = row.neg[mwdm_pkg::WH_FL] ? '0 : row.mag;
      want.fl_rev_duty = row.neg[mwdm_pkg::WH_FL] ? row.mag : '0;
      want.fr_fwd_duty = row.neg[mwdm_pkg::WH_FR] ? '0 : row.mag;
      want.fr_rev_duty = row.neg[mwdm_pkg::WH_FR] ? row.mag : '0;
      want.rl_fwd_duty = row.neg[mwdm_pkg::WH_RL] ? '0 : row.mag;
      want.rl_rev_duty = row.neg[mwdm_pkg::WH_RL] ? row.mag : '0;
      want.rr_fwd_duty = row.neg[mwdm_pkg::WH_RR] ? '0 : row.mag;
      want.rr_rev_duty = row.neg[mwdm_pkg::WH_RR] ? row.mag : '0;
      send_cmd(row.c, row.typed, want);
    end

    for (p = 0; p < PHASES; p++) begin
      cmd_ch.valid <= 1'b0;
      wait_drained();
      setting = cfg_rows[p];
      if (setting.rnd) begin
        setting.wheel_base = CFG_DATA_W'($urandom);
        setting.max_vel    = CFG_DATA_W'($urandom_range(32767, 1));
        setting.max_duty   = CFG_DATA_W'($urandom_range(65535, 1));
      end
      write_reg(mwdm_pkg::CFG_WHEEL_BASE, setting.wheel_base);
      write_reg(mwdm_pkg::CFG_MAX_VEL, setting.max_vel);
      write_reg(mwdm_pkg::CFG_MAX_DUTY, setting.max_duty);
      if (setting.poke_unused) write_reg(CFG_UNUSED, 16'hFFFF);
      cfg_we <= 1'b0;
      // receiver-heavy gaps, then sender-heavy, then full rate
      send_idle = (p < 3) ? 19 : (p < 6) ? 49 : 0;
      recv_idle = (p < 3) ? 49 : (p < 6) ? 19 : 0;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) begin
          cmd_ch.valid <= 1'b0;
          wait_drained();
        end
        send_cmd(random_cmd(), 1'b0, '0);
      end
    end

    cmd_ch.valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/mwdm_pkg.sv
rtl/mwdm_ifs.sv
rtl/mwdm_front.sv
rtl/mwdm_queue.sv
rtl/mwdm_back.sv
rtl/mecanum_wheel_duty_mixer_core.sv
rtl/mwdm_checker.sv
sim/tb_top.sv
